### rtl/mpf_pkg.sv
// shared constants, types and codes for the multilevel priority fifo
package mpf_pkg;

  localparam int LEVELS      = 8;
  localparam int LEVEL_DEPTH = 16;
  localparam int ID_WIDTH    = 8;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);
  localparam int TOT_W  = $clog2(LEVELS * LEVEL_DEPTH + 1);

  localparam int PID_PORT_W   = 8;
  localparam int PRIO_PORT_W  = 4;
  localparam int TOTAL_PORT_W = 8;

  typedef enum logic {
    KIND_ADD    = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BAD_PRIO  = 2'd3
  } status_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [ADDR_W-1:0]   addr;
    logic [ID_WIDTH-1:0] wdata;
  } store_req_t;

  typedef struct packed {
    logic             id_valid;
    status_t          status;
    logic [TOT_W-1:0] total;
    logic             empty;
  } result_t;

endpackage

### rtl/multilevel_priority_fifo.sv
// top level of the multilevel priority fifo
//
// Holds identifiers in one first-in first-out list per priority level.
// Input channel (in_valid/in_ready): in_kind selects add or remove,
// in_process_id is the identifier to add, in_priority_req its level
// (1 is served first). A remove pops the head of the lowest-numbered
// non-empty level.
// Result channel (out_valid/out_ready): one beat per input beat carrying
// the popped identifier (out_id, qualified by out_out_valid), a status
// (ok, remove while empty, level full, bad priority), the total count held
// afterwards and an empty flag. Rejected items change nothing.
// Latency: the result beat is valid the cycle after the input beat.
// Throughput: one item per cycle; the queue state updates at the input
// beat and the identifier memory read lands in its read register as the
// result register loads.
// Reset clears all levels at once; the identifier memory is not cleared.
// When the receiver stalls, the single result register holds its beat and
// in_ready drops until that beat is taken; taking it frees the register
// for a new input beat in the same cycle.
module multilevel_priority_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic [mpf_pkg::PID_PORT_W-1:0]   in_process_id,
  input  logic [mpf_pkg::PRIO_PORT_W-1:0]  in_priority_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mpf_pkg::PID_PORT_W-1:0]   out_id,
  output logic                             out_out_valid,
  output logic [1:0]                       out_status,
  output logic [mpf_pkg::TOTAL_PORT_W-1:0] out_total_entries,
  output logic                             out_is_empty
);
  import mpf_pkg::*;

  logic                accept;
  store_req_t          mem_req;
  result_t             res;
  result_t             res_r;
  logic                out_valid_r;
  logic [ID_WIDTH-1:0] rd_data;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  mpf_level_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .kind         (in_kind),
    .process_id   (in_process_id),
    .priority_req (in_priority_req),
    .mem_req      (mem_req),
    .res          (res)
  );

  mpf_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_id            = res_r.id_valid ? PID_PORT_W'(rd_data) : '0;
  assign out_out_valid     = res_r.id_valid;
  assign out_status        = res_r.status;
  assign out_total_entries = TOTAL_PORT_W'(res_r.total);
  assign out_is_empty      = res_r.empty;

endmodule

### rtl/mpf_store.sv
// identifier storage for all levels, one write or one registered read per cycle
module mpf_store (
  input  logic                         clk,
  input  mpf_pkg::store_req_t          req,
  output logic [mpf_pkg::ID_WIDTH-1:0] rd_data
);
  import mpf_pkg::*;

  logic [ID_WIDTH-1:0] mem [LEVELS*LEVEL_DEPTH];
  logic [ID_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/mpf_level_ctrl.sv
// per-level head and fill tracking, level selection and status decision
module mpf_level_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic                            kind,
  input  logic [mpf_pkg::PID_PORT_W-1:0]  process_id,
  input  logic [mpf_pkg::PRIO_PORT_W-1:0] priority_req,
  output mpf_pkg::store_req_t             mem_req,
  output mpf_pkg::result_t                res
);
  import mpf_pkg::*;

  logic [PTR_W-1:0]  head_r  [LEVELS];
  logic [PTR_W-1:0]  head_nxt[LEVELS];
  logic [FILL_W-1:0] fill_r  [LEVELS];
  logic [FILL_W-1:0] fill_nxt[LEVELS];
  logic [TOT_W-1:0]  total_r;
  logic [TOT_W-1:0]  total_nxt;

  logic              found;
  logic [LVL_W-1:0]  sel_lv;
  logic [LVL_W-1:0]  add_lv;
  logic              prio_bad;
  logic              lvl_full;
  logic [PTR_W:0]    pos_sum;
  logic [PTR_W-1:0]  pos;
  logic [ADDR_W-1:0] base;

  always_comb begin
    found  = 1'b0;
    sel_lv = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (!found && (fill_r[i] != '0)) begin
        found  = 1'b1;
        sel_lv = LVL_W'(i);
      end
    end
  end

  always_comb begin
    prio_bad = (priority_req == '0) || (int'(priority_req) > LEVELS);
    add_lv   = LVL_W'(int'(priority_req) - 1);
    lvl_full = (fill_r[add_lv] == FILL_W'(LEVEL_DEPTH));
    pos_sum  = (PTR_W+1)'(head_r[add_lv]) + (PTR_W+1)'(fill_r[add_lv]);
    if (pos_sum >= (PTR_W+1)'(LEVEL_DEPTH)) begin
      pos_sum = pos_sum - (PTR_W+1)'(LEVEL_DEPTH);
    end
    pos = PTR_W'(pos_sum);
  end

  always_comb begin
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.wdata = ID_WIDTH'(process_id);
    res.id_valid  = 1'b0;
    res.status    = STAT_OK;
    base          = '0;
    mem_req.addr  = '0;
    if (kind == KIND_ADD) begin
      base         = ADDR_W'(add_lv) * ADDR_W'(LEVEL_DEPTH);
      mem_req.addr = base + ADDR_W'(pos);
      if (prio_bad) begin
        res.status = STAT_BAD_PRIO;
      end else if (lvl_full) begin
        res.status = STAT_FULL;
      end else begin
        mem_req.we       = accept;
        fill_nxt[add_lv] = fill_r[add_lv] + FILL_W'(1);
        total_nxt        = total_r + TOT_W'(1);
      end
    end else begin
      base         = ADDR_W'(sel_lv) * ADDR_W'(LEVEL_DEPTH);
      mem_req.addr = base + ADDR_W'(head_r[sel_lv]);
      if (!found) begin
        res.status = STAT_EMPTY;
      end else begin
        mem_req.re   = accept;
        res.id_valid = 1'b1;
        if (head_r[sel_lv] == PTR_W'(LEVEL_DEPTH - 1)) begin
          head_nxt[sel_lv] = '0;
        end else begin
          head_nxt[sel_lv] = head_r[sel_lv] + PTR_W'(1);
        end
        fill_nxt[sel_lv] = fill_r[sel_lv] - FILL_W'(1);
        total_nxt        = total_r - TOT_W'(1);
      end
    end
    res.total = total_nxt;
    res.empty = (total_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
      total_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

### sim/multilevel_priority_fifo_checker.sv
// checker for the multilevel priority fifo: predicts every result beat and compares it
`timescale 1ns / 1ps

module multilevel_priority_fifo_checker
  import mpf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_kind,
  input  logic [PID_PORT_W-1:0]     in_process_id,
  input  logic [PRIO_PORT_W-1:0]    in_priority_req,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [PID_PORT_W-1:0]     out_id,
  input  logic                      out_out_valid,
  input  logic [1:0]                out_status,
  input  logic [TOTAL_PORT_W-1:0]   out_total_entries,
  input  logic                      out_is_empty,
  output logic [31:0]               error_count,
  output logic [31:0]               pending
);

  typedef struct {
    logic [PID_PORT_W-1:0]   id;
    logic                    id_valid;
    status_t                 status;
    logic [TOTAL_PORT_W-1:0] total;
    logic                    empty;
  } reply_t;

  logic [ID_WIDTH-1:0] slot_id [LEVELS][LEVEL_DEPTH];
  int                  level_rd  [LEVELS];
  int                  level_cnt [LEVELS];
  int                  held_total;
  reply_t              reply_fifo [$];

  initial begin
    error_count = 0;
    pending     = 0;
  end

  function automatic reply_t serve_request(kind_t kind, logic [PID_PORT_W-1:0] pid,
                                           logic [PRIO_PORT_W-1:0] prio);
    reply_t r;
    int     lv;
    int     pos;
    bit     found;
    r.id       = '0;
    r.id_valid = 1'b0;
    r.status   = STAT_OK;
    found      = 1'b0;
    if (kind == KIND_ADD) begin
      if (prio < 1 || prio > LEVELS) begin
        r.status = STAT_BAD_PRIO;
      end else begin
        lv = int'(prio) - 1;
        if (level_cnt[lv] >= LEVEL_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          pos = (level_rd[lv] + level_cnt[lv]) % LEVEL_DEPTH;
          slot_id[lv][pos] = pid[ID_WIDTH-1:0];
          level_cnt[lv]++;
          held_total++;
        end
      end
    end else begin
      for (lv = 0; lv < LEVELS && !found; lv++) begin
        if (level_cnt[lv] != 0) begin
          found      = 1'b1;
          r.id       = PID_PORT_W'(slot_id[lv][level_rd[lv]]);
          r.id_valid = 1'b1;
          level_rd[lv] = (level_rd[lv] + 1) % LEVEL_DEPTH;
          level_cnt[lv]--;
          held_total--;
        end
      end
      if (!found) r.status = STAT_EMPTY;
    end
    r.total = TOTAL_PORT_W'(held_total);
    r.empty = (held_total == 0);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count = error_count + 1;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        level_rd[i]  = 0;
        level_cnt[i] = 0;
      end
      held_total = 0;
      reply_fifo.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reply_fifo.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none actual id %0d",
                   $time, out_id);
          error_count = error_count + 1;
        end else begin
          want = reply_fifo.pop_front();
          check_field("out_id", want.id, out_id);
          check_field("out_out_valid", want.id_valid, out_out_valid);
          check_field("out_status", want.status, out_status);
          check_field("out_total_entries", want.total, out_total_entries);
          check_field("out_is_empty", want.empty, out_is_empty);
        end
      end
      if (in_valid && in_ready)
        reply_fifo.push_back(serve_request(kind_t'(in_kind), in_process_id, in_priority_req));
    end
    pending <= reply_fifo.size();
  end

endmodule

### sim/multilevel_priority_fifo_tb.sv
// testbench top for the multilevel priority fifo: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module multilevel_priority_fifo_tb;
  import mpf_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 60;
  localparam logic [PRIO_PORT_W-1:0] PRIO_TOP  = PRIO_PORT_W'(LEVELS);
  localparam logic [PRIO_PORT_W-1:0] PRIO_OVER = PRIO_PORT_W'(LEVELS + 1);
  localparam logic [PRIO_PORT_W-1:0] PRIO_MAX  = {PRIO_PORT_W{1'b1}};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_kind = KIND_ADD;
  logic [PID_PORT_W-1:0]   in_process_id = '0;
  logic [PRIO_PORT_W-1:0]  in_priority_req = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [PID_PORT_W-1:0]   out_id;
  logic                    out_out_valid;
  logic [1:0]              out_status;
  logic [TOTAL_PORT_W-1:0] out_total_entries;
  logic                    out_is_empty;

  logic [31:0] error_count;
  logic [31:0] pending;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  int   hold_cnt       = 0;
  int   quiet_cycles   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  multilevel_priority_fifo u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_process_id     (in_process_id),
    .in_priority_req   (in_priority_req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_id            (out_id),
    .out_out_valid     (out_out_valid),
    .out_status        (out_status),
    .out_total_entries (out_total_entries),
    .out_is_empty      (out_is_empty)
  );

  multilevel_priority_fifo_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_process_id     (in_process_id),
    .in_priority_req   (in_priority_req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_id            (out_id),
    .out_out_valid     (out_out_valid),
    .out_status        (out_status),
    .out_total_entries (out_total_entries),
    .out_is_empty      (out_is_empty),
    .error_count       (error_count),
    .pending           (pending)
  );

  // receiver: one long hold-off on request, else random stalls
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("multilevel_priority_fifo_tb: done, errors");
      $finish;
    end
  end

  task automatic send_beat(kind_t kind, logic [PID_PORT_W-1:0] pid,
                           logic [PRIO_PORT_W-1:0] prio);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_process_id   <= pid;
    in_priority_req <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(int n, int add_pct);
    kind_t                  kind;
    logic [PRIO_PORT_W-1:0] prio;
    for (int i = 0; i < n; i++) begin
      kind = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_REMOVE;
      if ($urandom_range(0, 9) == 0)
        prio = PRIO_PORT_W'($urandom_range(0, PRIO_MAX));
      else
        prio = PRIO_PORT_W'($urandom_range(1, LEVELS));
      send_beat(kind, PID_PORT_W'($urandom_range(0, 255)), prio);
    end
  endtask

  task automatic set_traffic(int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner cases: empty pop, bad levels, service order, one level overflow
    set_traffic(0, 0);
    send_beat(KIND_REMOVE, 8'h00, 4'd0);
    send_beat(KIND_ADD, 8'h5a, 4'd0);
    send_beat(KIND_ADD, 8'h5a, PRIO_OVER);
    send_beat(KIND_ADD, 8'ha5, PRIO_MAX);
    send_beat(KIND_ADD, 8'hff, PRIO_TOP);
    send_beat(KIND_ADD, 8'h00, 4'd1);
    send_beat(KIND_REMOVE, 8'hff, PRIO_MAX);
    send_beat(KIND_REMOVE, 8'h00, 4'd0);
    for (int i = 0; i <= LEVEL_DEPTH; i++)
      send_beat(KIND_ADD, PID_PORT_W'(i * 17), 4'd3);

    // receiver held off while the sender keeps offering
    hold_req <= 1'b1;
    send_random(30, 50);

    // fill every level past full, then drain past empty
    set_traffic(76, 0);
    for (int i = 0; i < LEVELS * (LEVEL_DEPTH + 1); i++)
      send_beat(KIND_ADD, PID_PORT_W'($urandom_range(0, 255)),
                PRIO_PORT_W'(i % LEVELS + 1));
    set_traffic(0, 76);
    for (int i = 0; i < LEVELS * LEVEL_DEPTH + 2; i++)
      send_beat(KIND_REMOVE, PID_PORT_W'($urandom_range(0, 255)),
                PRIO_PORT_W'($urandom_range(0, PRIO_MAX)));

    set_traffic(29, 29);
    send_random(25, 60);
    set_traffic(0, 0);
    send_random(25, 55);
    set_traffic(76, 0);
    send_random(25, 45);
    set_traffic(0, 76);
    send_random(25, 50);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0)
      $display("multilevel_priority_fifo_tb: done, clean");
    else
      $display("multilevel_priority_fifo_tb: done, errors");
    $finish;
  end

endmodule
